// ===== rtl/sfm_pkg.sv =====
package sfm_pkg;

  localparam int unsigned MaxPatternLenDefault = 16;
  localparam int unsigned MaxTextLenDefault    = 65535;

  localparam int unsigned PatBytes  = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 64;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOWER  = 2'd1,
    CFG_PATTERN_UPPER  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_item_t;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] match_start;
  } match_item_t;

endpackage

// ===== rtl/substring_first_match_core.sv =====
// Channel | Direction | Handshake                | Item
// in      | input     | in_valid_i / in_stall_o  | in_item_i  (text_item_t)
// out     | output    | out_valid_o / out_stall_i| out_item_o (match_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle unless stalled; path is input register, then result register.
// The window compare against the pattern is combinational between the two registers.
// Reset clears text state and sets pattern length 1, pattern bytes zero.
// out_stall_i with both registers full stalls the input in the same cycle.
// cfg_ready_o is always high; write configuration only while idle.
module substring_first_match_core
  import sfm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_LEN = MaxPatternLenDefault,
  parameter int unsigned MAX_TEXT_LEN    = MaxTextLenDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  text_item_t           in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output match_item_t          out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam logic [CountW-1:0] TextMax = CountW'(MAX_TEXT_LEN);
  localparam logic [LenW-1:0]   LenMax  = LenW'(MAX_PATTERN_LEN);

  logic [LenW-1:0]     len_raw_q;
  logic [CfgDataW-1:0] pat_lower_q, pat_upper_q;

  logic        s1_valid_q;
  text_item_t  s1_item_q;
  logic        advance;

  logic [7:0]        win_q [MAX_PATTERN_LEN];
  logic [7:0]        win_d [MAX_PATTERN_LEN];
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              rep_q, rep_d;

  logic        out_valid_q;
  match_item_t out_item_q;
  logic        res_valid;
  match_item_t res_item;

  logic [7:0]      pat [PatBytes];
  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] pidx;
  logic            in_range;
  logic            hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_raw_q   <= LenW'(1);
      pat_lower_q <= '0;
      pat_upper_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PATTERN_LENGTH: len_raw_q   <= cfg_data_i[LenW-1:0];
        CFG_PATTERN_LOWER:  pat_lower_q <= cfg_data_i;
        CFG_PATTERN_UPPER:  pat_upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < PatBytes; k++) begin
      if (k < 8) begin
        pat[k] = pat_lower_q[8*k +: 8];
      end else begin
        pat[k] = pat_upper_q[8*(k-8) +: 8];
      end
    end
    if (len_raw_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_raw_q > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = len_raw_q;
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  always_comb begin
    in_range = cnt_q < TextMax;
    win_d[0] = s1_item_q.text_byte;
    for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
      win_d[j] = win_q[j-1];
    end
    cnt_d = cnt_q + CountW'(1);
    hit   = !rep_q && in_range && (cnt_d >= CountW'(len_eff));
    pidx  = '0;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      if (LenW'(j) < len_eff) begin
        pidx = len_eff - LenW'(1) - LenW'(j);
        if (win_d[j] != pat[pidx[3:0]]) begin
          hit = 1'b0;
        end
      end
    end
    res_valid            = hit || (s1_item_q.last_byte && !rep_q);
    res_item.found       = hit;
    res_item.match_start = hit ? (cnt_d - CountW'(len_eff) + CountW'(1)) : '0;
    rep_d                = rep_q || hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rep_q <= 1'b0;
    end else if (advance) begin
      if (s1_item_q.last_byte) begin
        cnt_q <= '0;
        rep_q <= 1'b0;
      end else begin
        if (in_range) begin
          cnt_q <= cnt_d;
        end
        rep_q <= rep_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_range) begin
      for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.match_start == '0)
    else $error("not-found item with nonzero start");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> out_item_o.match_start != '0)
    else $error("found item with zero start");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_item_q.last_byte |=> cnt_q == '0 && !rep_q)
    else $error("text state not cleared after last byte");

  a_rep_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q |-> cnt_q != '0)
    else $error("match reported with empty count");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== dv/substring_first_match_checker.sv =====
module substring_first_match_checker
  import sfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  text_item_t           in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  match_item_t          out_item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  logic [LenW-1:0]     pat_len;
  logic [CfgDataW-1:0] pat_lo;
  logic [CfgDataW-1:0] pat_hi;
  logic [7:0]          window [PatBytes];
  int unsigned         text_len;
  logic                reported;
  int                  errors;
  match_item_t         expected_matches [$];

  always @(posedge clk_i or negedge rst_ni) begin : track
    match_item_t want;
    int unsigned n;
    logic        hit;
    logic        gave;
    if (!rst_ni) begin
      pat_len = LenW'(1);
      pat_lo = '0;
      pat_hi = '0;
      for (int i = 0; i < PatBytes; i++) window[i] = 8'h00;
      text_len = 0;
      reported = 1'b0;
      errors = 0;
      expected_matches.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_matches.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual found=%0b start=%0d",
                   $time, out_item_i.found, out_item_i.match_start);
        end else begin
          want = expected_matches.pop_front();
          if (out_item_i.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0b actual %0b",
                     $time, want.found, out_item_i.found);
          end
          if (out_item_i.match_start !== want.match_start) begin
            errors++;
            $display("%0t: match_start expected %0d actual %0d",
                     $time, want.match_start, out_item_i.match_start);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        gave = 1'b0;
        if (text_len < MaxTextLenDefault) begin
          n = 32'(pat_len);
          if (n == 0) n = 1;
          if (n > PatBytes) n = PatBytes;
          for (int i = PatBytes - 1; i > 0; i--) window[i] = window[i-1];
          window[0] = in_item_i.text_byte;
          text_len++;
          if (!reported && text_len >= n) begin
            hit = 1'b1;
            // pattern byte 1 lines up with the oldest byte of the window span
            for (int k = 1; k <= n; k++) begin
              if (window[n-k] != ((k <= 8) ? pat_lo[8*(k-1) +: 8] : pat_hi[8*(k-9) +: 8]))
                hit = 1'b0;
            end
            if (hit) begin
              reported = 1'b1;
              gave = 1'b1;
              expected_matches.push_back(match_item_t'{found: 1'b1,
                                                      match_start: 16'(text_len - n + 1)});
            end
          end
        end
        if (in_item_i.last_byte) begin
          if (!gave && !reported)
            expected_matches.push_back(match_item_t'{found: 1'b0, match_start: '0});
          for (int i = 0; i < PatBytes; i++) window[i] = 8'h00;
          text_len = 0;
          reported = 1'b0;
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PATTERN_LENGTH: pat_len = cfg_data_i[LenW-1:0];
          CFG_PATTERN_LOWER:  pat_lo = cfg_data_i;
          CFG_PATTERN_UPPER:  pat_hi = cfg_data_i;
          default: ;
        endcase
      end

      errors_o <= errors;
      pending_o <= expected_matches.size();
    end
  end

endmodule

// ===== dv/substring_first_match_core_tb.sv =====
module substring_first_match_core_tb;
  import sfm_pkg::*;

  localparam int unsigned RunLimit      = 500000;
  localparam int unsigned TargetItems   = 1150;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [CfgIndexW-1:0] CfgIndexUnused = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  text_item_t           in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  match_item_t          out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  int                   errors;
  int                   pending;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          holdoff_reqs = 0;
  int          holdoff_done = 0;
  int          cycles = 0;
  int          sent = 0;
  logic [7:0]  pat_bytes [PatBytes];
  int          pat_n = 1;
  logic [7:0]  alpha_base = 8'h61;

  substring_first_match_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  substring_first_match_checker u_match_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_done != holdoff_reqs) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        holdoff_done++;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= text_item_t'{text_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // drain: every predicted result back, then let result-less items pass through
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_pattern(input logic [LenW-1:0] code, input logic [63:0] lo,
                              input logic [63:0] hi);
    logic [63:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LenW-1:0] = code;
    write_reg(CFG_PATTERN_LENGTH, len_word);
    write_reg(CFG_PATTERN_LOWER, lo);
    write_reg(CFG_PATTERN_UPPER, hi);
    pat_n = (code == 0) ? 1 : (code > PatBytes) ? int'(PatBytes) : int'(code);
    for (int k = 0; k < PatBytes; k++)
      pat_bytes[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
  endtask

  task automatic random_pattern();
    logic [63:0]     lo;
    logic [63:0]     hi;
    logic [LenW-1:0] code;
    int              r;
    r = $urandom_range(99);
    code = (r < 70) ? LenW'($urandom_range(1, 5)) : (r < 90) ? LenW'($urandom_range(6, 16)) :
           (r < 95) ? 5'd0 : LenW'($urandom_range(17, 31));
    alpha_base = 8'($urandom);
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    if ($urandom_range(9) != 0) begin
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = 8'(alpha_base + $urandom_range(2));
        hi[8*k +: 8] = 8'(alpha_base + $urandom_range(2));
      end
    end
    load_pattern(code, lo, hi);
  endtask

  task automatic send_text(input int n, input bit plant, input bit noise);
    logic [7:0] text_q [$];
    int         at;
    for (int i = 0; i < n; i++)
      text_q.push_back(noise ? 8'($urandom) : 8'(alpha_base + $urandom_range(2)));
    if (plant && n >= pat_n) begin
      at = $urandom_range(0, n - pat_n);
      for (int k = 0; k < pat_n; k++) text_q[at+k] = pat_bytes[k];
    end
    for (int i = 0; i < n; i++) push_byte(text_q[i], i == n - 1);
  endtask

  task automatic random_texts(input int upto);
    int r;
    while (sent < upto) begin
      r = $urandom_range(99);
      if (r < 20) begin
        // sometimes leave a text open across the register change
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 5)) push_byte(8'(alpha_base + $urandom_range(2)), 1'b0);
        settle();
        if ($urandom_range(7) == 0) write_reg(CfgIndexUnused, {$urandom, $urandom});
        random_pattern();
      end
      if (r >= 90)
        send_text(1, 1'($urandom_range(1)), 1'b0);
      else
        send_text($urandom_range(2, 24), $urandom_range(99) < 60, $urandom_range(99) < 15);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 16;
    recv_idle_pct = 63;

    // reset pattern is a single zero byte
    push_byte(8'h00, 1'b1);
    settle();

    // first match only, later match in same text ignored
    load_pattern(5'd3, {$urandom, 8'($urandom), 24'h636261}, {$urandom, $urandom});
    push_byte(8'h78, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h63, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h63, 1'b1);

    // pattern swapped mid-text, window carries the earlier bytes
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    settle();
    load_pattern(5'd2, {$urandom, 16'($urandom), 16'h7162}, {$urandom, $urandom});
    push_byte(8'h71, 1'b1);

    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    write_reg(CfgIndexUnused, {$urandom, $urandom});
    load_pattern(5'd0, {$urandom, 24'($urandom), 8'hFF}, {$urandom, $urandom});
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // oversized length clamps to full 16-byte pattern, match on last byte
    load_pattern(5'd31, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < PatBytes; i++) push_byte((i < 8) ? 8'h00 : 8'hFF, i == PatBytes - 1);
    settle();

    random_pattern();
    random_texts(400);

    send_idle_pct = 63;
    recv_idle_pct = 16;
    random_texts(780);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_reqs++;
    for (int i = 0; i < 40; i++) push_byte(8'($urandom), 1'b1);
    random_texts(TargetItems);
    settle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sfm_pkg.sv
rtl/substring_first_match_core.sv
dv/substring_first_match_checker.sv
dv/substring_first_match_core_tb.sv
